// File: hw/rtl/random_forest_inference_defines.svh
// ---------------------------------------------------------------------------
// random forest inference assertion macros
// concurrent assertion wrappers clocked on clk, with a compile-time switch
// ---------------------------------------------------------------------------
`ifndef RANDOM_FOREST_INFERENCE_DEFINES_SVH
`define RANDOM_FOREST_INFERENCE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define RFI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define RFI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RFI_ASSERT(label, prop, msg)
`define RFI_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: hw/rtl/rfi_pkg.sv
// ---------------------------------------------------------------------------
// rfi_pkg
// shared types and constants of the random forest inference block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfi_pkg;

  localparam int TREE_IDX_W   = 5;
  localparam int NODE_IDX_W   = 9;
  localparam int NODE_FEAT_W  = 7;
  localparam int FEAT_IDX_W   = 6;
  localparam int VALUE_W      = 32;
  localparam int PROB_W       = 16;
  localparam int TREE_COUNT_W = 6;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [TREE_COUNT_W-1:0] TREE_COUNT_RESET = 6'd12;
  localparam logic [PROB_W-1:0]       THRESHOLD_RESET  = 16'd32768;

  localparam logic [CFG_INDEX_W-1:0] REG_TREE_COUNT       = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DECIDE_THRESHOLD = 1'b1;

  localparam logic REQ_NODE    = 1'b0;
  localparam logic REQ_FEATURE = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0]     value;
    logic [NODE_IDX_W-1:0]  right;
    logic [NODE_IDX_W-1:0]  left;
    logic [NODE_FEAT_W-1:0] feature;
  } node_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DECODE,
    ST_COMPARE,
    ST_DIVIDE,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic walk_init;
    logic leaf_add;
    logic raise_fault;
    logic tree_next;
    logic child_take;
    logic div_start;
    logic result_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_leaf;
    logic depth_hit;
    logic child_bad;
    logic last_tree;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/rfi_div.sv
// ---------------------------------------------------------------------------
// rfi_div
// restoring unsigned divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfi_div #(
  parameter int DVD_W = 21,
  parameter int DVS_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             q_bit;

  assign trial = {rem, quotient[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign q_bit = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= q_bit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quotient <= {quotient[DVD_W-2:0], q_bit};
    end
  end

endmodule

// File: hw/rtl/rfi_ctrl.sv
// ---------------------------------------------------------------------------
// rfi_ctrl
// sequencer for input transfers, tree walks, averaging and result hand-off
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfi_ctrl
  import rfi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       req_type,
  input  logic       last_feature,
  input  dp_status_t stat,
  output logic       in_stall,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && req_type == REQ_FEATURE && last_feature) begin
          cmd.walk_init = 1'b1;
          state_next    = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat.is_leaf || stat.depth_hit) begin
          cmd.leaf_add    = stat.is_leaf;
          cmd.raise_fault = !stat.is_leaf;
          if (stat.last_tree) begin
            state_next = ST_DIVIDE;
          end else begin
            cmd.tree_next = 1'b1;
            state_next    = ST_READ;
          end
        end else begin
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        if (stat.child_bad) begin
          cmd.raise_fault = 1'b1;
          if (stat.last_tree) begin
            state_next = ST_DIVIDE;
          end else begin
            cmd.tree_next = 1'b1;
            state_next    = ST_READ;
          end
        end else begin
          cmd.child_take = 1'b1;
          state_next     = ST_READ;
        end
      end
      ST_DIVIDE: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!stat.div_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the result register is free or drains this cycle
        if (stat.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/rfi_datapath.sv
// ---------------------------------------------------------------------------
// rfi_datapath
// node store, feature buffer, walk registers, leaf sum, divider and result
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "random_forest_inference_defines.svh"

module rfi_datapath
  import rfi_pkg::*;
#(
  parameter int NUM_FEATURES   = 44,
  parameter int MAX_TREES      = 32,
  parameter int NODES_PER_TREE = 512,
  parameter int DEPTH_LIMIT    = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      req_type,
  input  logic [TREE_IDX_W-1:0]     tree_index,
  input  logic [NODE_IDX_W-1:0]     node_index,
  input  logic signed [NODE_FEAT_W-1:0] node_feature,
  input  logic [NODE_IDX_W-1:0]     node_left,
  input  logic [NODE_IDX_W-1:0]     node_right,
  input  logic signed [VALUE_W-1:0] node_value,
  input  logic [FEAT_IDX_W-1:0]     feature_index,
  input  logic signed [VALUE_W-1:0] feature_value,
  input  ctrl_cmd_t                 cmd,
  output dp_status_t                stat,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [PROB_W-1:0]         forest_prob,
  output logic                      decision,
  output logic                      walk_fault
);

  localparam int ST_DEPTH = MAX_TREES * NODES_PER_TREE;
  localparam int ST_AW    = $clog2(ST_DEPTH);
  localparam int NODE_AW  = $clog2(NODES_PER_TREE);
  localparam int FEAT_AW  = $clog2(NUM_FEATURES);
  localparam int TC_W     = $clog2(MAX_TREES + 1);
  localparam int STEP_W   = $clog2(DEPTH_LIMIT + 1);
  localparam int SUM_W    = PROB_W + $clog2(MAX_TREES);

  logic [TREE_COUNT_W-1:0] tree_count;
  logic [PROB_W-1:0]       decide_threshold;

  node_t                node_mem [ST_DEPTH];
  logic [VALUE_W-1:0]   feat_mem [NUM_FEATURES];
  node_t                node_q;
  logic [VALUE_W-1:0]   feat_q;
  logic                 feat_zero;

  logic [TC_W-1:0]      tree;
  logic [TC_W-1:0]      trees;
  logic [NODE_AW-1:0]   node_ptr;
  logic [STEP_W-1:0]    steps;
  logic [SUM_W-1:0]     sum;
  logic                 fault;

  logic                 node_we;
  logic [ST_AW-1:0]     node_waddr;
  logic [ST_AW-1:0]     node_raddr;
  node_t                node_wdata;
  logic                 feat_we;
  logic [FEAT_AW-1:0]   feat_raddr;
  logic [TC_W-1:0]      trees_clamped;
  logic [PROB_W-1:0]    leaf_prob;
  logic signed [VALUE_W-1:0] feat_cmp;
  logic [NODE_IDX_W-1:0] child;
  logic                 div_busy;
  logic [SUM_W-1:0]     quotient;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tree_count       <= TREE_COUNT_RESET;
      decide_threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TREE_COUNT:       tree_count       <= cfg_data[TREE_COUNT_W-1:0];
        REG_DECIDE_THRESHOLD: decide_threshold <= cfg_data[PROB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // node store
  assign node_we = cmd.accept && req_type == REQ_NODE
                   && int'(tree_index) < MAX_TREES
                   && int'(node_index) < NODES_PER_TREE;
  assign node_waddr = ST_AW'(int'(tree_index) * NODES_PER_TREE + int'(node_index));
  assign node_raddr = ST_AW'(int'(tree) * NODES_PER_TREE + int'(node_ptr));
  assign node_wdata = '{value:   node_value,
                        right:   node_right,
                        left:    node_left,
                        feature: node_feature};

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_q <= node_mem[node_raddr];
  end

  // feature buffer, read at the split feature of the current node
  assign feat_we    = cmd.accept && req_type == REQ_FEATURE
                      && int'(feature_index) < NUM_FEATURES;
  assign feat_raddr = node_q.feature[FEAT_AW-1:0];

  always_ff @(posedge clk) begin
    if (feat_we) begin
      feat_mem[feature_index[FEAT_AW-1:0]] <= feature_value;
    end
    feat_q    <= feat_mem[feat_raddr];
    feat_zero <= (int'(node_q.feature) >= NUM_FEATURES);
  end

  // walk control and leaf accumulation
  always_comb begin
    if (tree_count == '0) begin
      trees_clamped = TC_W'(1);
    end else if (int'(tree_count) > MAX_TREES) begin
      trees_clamped = TC_W'(MAX_TREES);
    end else begin
      trees_clamped = TC_W'(tree_count);
    end
  end

  always_comb begin
    if (node_q.value[VALUE_W-1]) begin
      leaf_prob = '0;
    end else if (|node_q.value[VALUE_W-2:PROB_W]) begin
      leaf_prob = '1;
    end else begin
      leaf_prob = node_q.value[PROB_W-1:0];
    end
  end

  assign feat_cmp = feat_zero ? '0 : $signed(feat_q);
  assign child    = (feat_cmp < $signed(node_q.value)) ? node_q.left : node_q.right;

  always_ff @(posedge clk) begin
    if (rst) begin
      tree     <= '0;
      trees    <= TC_W'(1);
      node_ptr <= '0;
      steps    <= '0;
      fault    <= 1'b0;
    end else if (cmd.walk_init) begin
      tree     <= '0;
      trees    <= trees_clamped;
      node_ptr <= '0;
      steps    <= '0;
      fault    <= 1'b0;
    end else begin
      if (cmd.raise_fault) begin
        fault <= 1'b1;
      end
      if (cmd.tree_next) begin
        tree     <= tree + 1'b1;
        node_ptr <= '0;
        steps    <= '0;
      end else if (cmd.child_take) begin
        node_ptr <= NODE_AW'(child);
        steps    <= steps + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      sum <= '0;
    end else if (cmd.leaf_add) begin
      sum <= sum + SUM_W'(leaf_prob);
    end
  end

  rfi_div #(
    .DVD_W (SUM_W),
    .DVS_W (TC_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum),
    .divisor  (trees),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      forest_prob <= quotient[PROB_W-1:0];
      decision    <= (quotient[PROB_W-1:0] >= decide_threshold);
      walk_fault  <= fault;
    end
  end

  assign stat.is_leaf   = node_q.feature[NODE_FEAT_W-1];
  assign stat.depth_hit = (int'(steps) >= DEPTH_LIMIT);
  assign stat.child_bad = (int'(child) >= NODES_PER_TREE);
  assign stat.last_tree = ((int'(tree) + 1) == int'(trees));
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = !out_valid || !out_stall;

  `RFI_ASSERT(a_load_when_free, cmd.result_load |-> !(out_valid && out_stall), "result overwritten while stalled")
  `RFI_ASSERT(a_depth_bound, int'(steps) <= DEPTH_LIMIT, "walk step count past depth limit")
  `RFI_ASSERT(a_tree_bound, cmd.tree_next |-> (int'(tree) + 1) < int'(trees), "walk advanced past last tree")
  `RFI_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "result valid after reset")

endmodule

// File: hw/rtl/random_forest_inference.sv
// ---------------------------------------------------------------------------
// random_forest_inference
// node writes and non-final feature loads: one transfer per cycle, no result
// final feature: each tree is walked node by node (node read, feature read, compare),
//   then the serial divider averages the leaf sum and the result register is loaded
// no input transfer is taken while a classification runs
// reset clears control, sets tree_count 12 and decide_threshold one half
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module random_forest_inference
  import rfi_pkg::*;
#(
  parameter int NUM_FEATURES   = 44,
  parameter int MAX_TREES      = 32,
  parameter int NODES_PER_TREE = 512,
  parameter int DEPTH_LIMIT    = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [TREE_IDX_W-1:0]         tree_index,
  input  logic [NODE_IDX_W-1:0]         node_index,
  input  logic signed [NODE_FEAT_W-1:0] node_feature,
  input  logic [NODE_IDX_W-1:0]         node_left,
  input  logic [NODE_IDX_W-1:0]         node_right,
  input  logic signed [VALUE_W-1:0]     node_value,
  input  logic [FEAT_IDX_W-1:0]         feature_index,
  input  logic signed [VALUE_W-1:0]     feature_value,
  input  logic                          last_feature,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [PROB_W-1:0]             forest_prob,
  output logic                          decision,
  output logic                          walk_fault
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  rfi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .req_type     (req_type),
    .last_feature (last_feature),
    .stat         (stat),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  rfi_datapath #(
    .NUM_FEATURES   (NUM_FEATURES),
    .MAX_TREES      (MAX_TREES),
    .NODES_PER_TREE (NODES_PER_TREE),
    .DEPTH_LIMIT    (DEPTH_LIMIT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .tree_index    (tree_index),
    .node_index    (node_index),
    .node_feature  (node_feature),
    .node_left     (node_left),
    .node_right    (node_right),
    .node_value    (node_value),
    .feature_index (feature_index),
    .feature_value (feature_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .forest_prob   (forest_prob),
    .decision      (decision),
    .walk_fault    (walk_fault)
  );

endmodule

// File: verif/tb_random_forest_inference.sv
// ---------------------------------------------------------------------------
// tb_random_forest_inference
// self-checking bench for the forest classifier: loads trees and features,
// predicts every classification in a local copy of the node store and
// feature buffer, and checks each result transfer against it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_random_forest_inference;
  import rfi_pkg::*;

  localparam int NUM_FEAT      = 44;
  localparam int MAX_TREES     = 32;
  localparam int NODES         = 512;
  localparam int DEPTH_LIMIT   = 32;
  localparam int CLK_HALF      = 10;
  localparam int CYCLE_LIMIT   = 20000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 170;

  typedef struct packed {
    logic                   req;
    logic [TREE_IDX_W-1:0]  tree;
    logic [NODE_IDX_W-1:0]  node;
    logic [NODE_FEAT_W-1:0] nfeat;
    logic [NODE_IDX_W-1:0]  left;
    logic [NODE_IDX_W-1:0]  right;
    logic [VALUE_W-1:0]     nval;
    logic [FEAT_IDX_W-1:0]  fidx;
    logic [VALUE_W-1:0]     fval;
    logic                   last;
  } request_t;

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic              decision;
    logic              fault;
  } verdict_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [CFG_INDEX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic                          req_type;
  logic [TREE_IDX_W-1:0]         tree_index;
  logic [NODE_IDX_W-1:0]         node_index;
  logic signed [NODE_FEAT_W-1:0] node_feature;
  logic [NODE_IDX_W-1:0]         node_left;
  logic [NODE_IDX_W-1:0]         node_right;
  logic signed [VALUE_W-1:0]     node_value;
  logic [FEAT_IDX_W-1:0]         feature_index;
  logic signed [VALUE_W-1:0]     feature_value;
  logic                          last_feature;
  logic                          out_valid;
  logic                          out_stall;
  logic [PROB_W-1:0]             forest_prob;
  logic                          decision;
  logic                          walk_fault;

  random_forest_inference #(
    .NUM_FEATURES  (NUM_FEAT),
    .MAX_TREES     (MAX_TREES),
    .NODES_PER_TREE(NODES),
    .DEPTH_LIMIT   (DEPTH_LIMIT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .tree_index   (tree_index),
    .node_index   (node_index),
    .node_feature (node_feature),
    .node_left    (node_left),
    .node_right   (node_right),
    .node_value   (node_value),
    .feature_index(feature_index),
    .feature_value(feature_value),
    .last_feature (last_feature),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .forest_prob  (forest_prob),
    .decision     (decision),
    .walk_fault   (walk_fault)
  );

  // local copy of the block state
  node_t                   node_mem [MAX_TREES*NODES];
  bit                      node_written [MAX_TREES*NODES];
  logic [VALUE_W-1:0]      feat_mem [NUM_FEAT];
  logic [TREE_COUNT_W-1:0] tree_count_copy;
  logic [PROB_W-1:0]       threshold_copy;
  verdict_t                pending_verdicts [$];

  int fail_count;
  int items_sent;
  int verdicts_checked;
  int faults_seen;
  int cycle_count;
  bit gaps_on;
  bit hold_request;
  int hold_count;
  int burst_left;

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("random_forest_inference: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int trees_in_use();
    int n;
    n = int'(tree_count_copy);
    if (n == 0) n = 1;
    if (n > MAX_TREES) n = MAX_TREES;
    return n;
  endfunction

  // leaf probability of one tree, -1 when the walk runs too deep
  function automatic int tree_score(input int t);
    node_t                     n;
    int                        node;
    int                        depth;
    logic signed [VALUE_W-1:0] fv;
    node = 0;
    for (depth = 0; depth <= DEPTH_LIMIT; depth++) begin
      n = node_mem[t*NODES + node];
      if (n.feature[NODE_FEAT_W-1]) begin
        if ($signed(n.value) < 0) return 0;
        if ($signed(n.value) > 65535) return 65535;
        return n.value;
      end
      if (depth == DEPTH_LIMIT) return -1;
      fv = 0;
      if (n.feature < NUM_FEAT) fv = feat_mem[n.feature];
      node = (fv < $signed(n.value)) ? int'(n.left) : int'(n.right);
    end
    return -1;
  endfunction

  function automatic verdict_t forest_classify();
    int       trees;
    int       t;
    int       s;
    int       sum;
    int       mean;
    verdict_t v;
    trees = trees_in_use();
    sum = 0;
    v.fault = 1'b0;
    for (t = 0; t < trees; t++) begin
      s = tree_score(t);
      if (s < 0) v.fault = 1'b1;
      else sum += s;
    end
    mean = sum / trees;
    v.prob = mean[PROB_W-1:0];
    v.decision = (mean >= int'(threshold_copy));
    return v;
  endfunction

  function automatic void absorb_request(input request_t r);
    node_t n;
    if (r.req == REQ_NODE) begin
      n.feature = r.nfeat;
      n.left = r.left;
      n.right = r.right;
      n.value = r.nval;
      node_mem[r.tree*NODES + r.node] = n;
      node_written[r.tree*NODES + r.node] = 1'b1;
    end else begin
      if (r.fidx < NUM_FEAT) feat_mem[r.fidx] = r.fval;
      if (r.last) pending_verdicts.insert(pending_verdicts.size(), forest_classify());
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 20)
      $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result transfer with nothing pending, forest_prob",
                        int'(forest_prob), 0);
      end else begin
        exp_v = pending_verdicts.pop_front();
        verdicts_checked++;
        if (exp_v.fault) faults_seen++;
        if (forest_prob !== exp_v.prob)
          report_mismatch("forest_prob", int'(forest_prob), int'(exp_v.prob));
        if (decision !== exp_v.decision)
          report_mismatch("decision", int'(decision), int'(exp_v.decision));
        if (walk_fault !== exp_v.fault)
          report_mismatch("walk_fault", int'(walk_fault), int'(exp_v.fault));
      end
    end
  end

  // result side stall: random bursts, plus one long hold on request
  always @(negedge clk) begin
    if (hold_request) begin
      out_stall <= 1'b1;
      hold_count++;
      if (hold_count >= LONG_HOLD) begin
        hold_request = 1'b0;
        hold_count = 0;
      end
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else if (gaps_on && $urandom_range(0, 15) == 0) begin
      out_stall <= 1'b1;
      burst_left = $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_item(input request_t r);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r.req;
    tree_index <= r.tree;
    node_index <= r.node;
    node_feature <= r.nfeat;
    node_left <= r.left;
    node_right <= r.right;
    node_value <= r.nval;
    feature_index <= r.fidx;
    feature_value <= r.fval;
    last_feature <= r.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_request(r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input logic [TREE_COUNT_W-1:0] tc, input logic [PROB_W-1:0] thr);
    logic [CFG_DATA_W-1:0] tc_word;
    wait_for_drain();
    tc_word = CFG_DATA_W'($urandom);
    tc_word[TREE_COUNT_W-1:0] = tc;
    cfg_write <= 1'b1;
    cfg_index <= REG_TREE_COUNT;
    cfg_data <= tc_word;
    @(negedge clk);
    cfg_index <= REG_DECIDE_THRESHOLD;
    cfg_data <= thr;
    @(negedge clk);
    cfg_write <= 1'b0;
    tree_count_copy = tc;
    threshold_copy = thr;
  endtask

  // ---------------------------------------------------------------- item builders

  function automatic request_t node_write(input int t, input int slot,
                                          input logic [NODE_FEAT_W-1:0] feat,
                                          input int lch, input int rch,
                                          input logic [VALUE_W-1:0] val);
    logic [127:0] noise;
    request_t     r;
    noise = {$urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(request_t)-1:0];
    r.req = REQ_NODE;
    r.tree = t[TREE_IDX_W-1:0];
    r.node = slot[NODE_IDX_W-1:0];
    r.nfeat = feat;
    r.left = lch[NODE_IDX_W-1:0];
    r.right = rch[NODE_IDX_W-1:0];
    r.nval = val;
    return r;
  endfunction

  function automatic request_t feat_load(input int idx, input logic [VALUE_W-1:0] val,
                                         input bit last);
    logic [127:0] noise;
    request_t     r;
    noise = {$urandom, $urandom, $urandom, $urandom};
    r = noise[$bits(request_t)-1:0];
    r.req = REQ_FEATURE;
    r.fidx = idx[FEAT_IDX_W-1:0];
    r.fval = val;
    r.last = last;
    return r;
  endfunction

  // any negative code marks a leaf
  function automatic logic [NODE_FEAT_W-1:0] leaf_code();
    logic [31:0] w;
    w = $urandom;
    return {1'b1, w[NODE_FEAT_W-2:0]};
  endfunction

  function automatic logic [NODE_FEAT_W-1:0] split_code();
    logic [31:0] w;
    if ($urandom_range(0, 6) == 0) w = $urandom_range(NUM_FEAT, 63);
    else w = $urandom_range(0, NUM_FEAT-1);
    return w[NODE_FEAT_W-1:0];
  endfunction

  // shared by feature values and thresholds so that ties come up often
  function automatic logic [VALUE_W-1:0] rand_value();
    int          k;
    int          small_v;
    logic [31:0] v;
    k = $urandom_range(0, 5);
    case (k)
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: begin
        small_v = $urandom_range(0, 6);
        v = (small_v - 3) * 65536;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_prob();
    int          k;
    logic [31:0] v;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      v = $urandom_range(0, 65535);
    end else if (k < 8) begin
      v = $urandom;
      v[31] = 1'b1;
    end else begin
      v = $urandom_range(65536, 32'h7FFF_FFFF);
    end
    return v;
  endfunction

  function automatic int rand_feat_index();
    if ($urandom_range(0, 6) == 0) return $urandom_range(NUM_FEAT, 63);
    return $urandom_range(0, NUM_FEAT-1);
  endfunction

  function automatic int pick_written(input int t);
    int s;
    int k;
    s = $urandom_range(0, NODES-1);
    for (k = 0; k < NODES; k++) begin
      if (node_written[t*NODES + ((s + k) % NODES)]) return (s + k) % NODES;
    end
    return 0;
  endfunction

  function automatic int pick_tree();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, MAX_TREES-1);
    return $urandom_range(0, trees_in_use() - 1);
  endfunction

  // writes a subtree bottom-up: split children point only at nodes already
  // written, so no walk ever reaches an empty slot
  task automatic build_subtree(input int t);
    int slots [12];
    int k;
    int i;
    int j;
    int s;
    int c0;
    int c1;
    bit dup;
    bit with_root;
    k = $urandom_range(1, 10);
    with_root = ($urandom_range(0, 1) == 1);
    for (i = 0; i < k; i++) begin
      if (with_root && i == k-1 && i > 0) begin
        s = 0;
      end else begin
        dup = 1'b1;
        while (dup) begin
          s = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 31) : $urandom_range(1, NODES-1);
          dup = 1'b0;
          for (j = 0; j < i; j++) if (slots[j] == s) dup = 1'b1;
        end
      end
      slots[i] = s;
      if (i == 0 || $urandom_range(0, 3) == 0) begin
        send_item(node_write(t, s, leaf_code(), $urandom_range(0, NODES-1),
                             $urandom_range(0, NODES-1), rand_prob()));
      end else begin
        // now and then a child anywhere in the tree, which may close a loop
        c0 = ($urandom_range(0, 19) == 0) ? pick_written(t) : slots[$urandom_range(0, i-1)];
        c1 = ($urandom_range(0, 19) == 0) ? pick_written(t) : slots[$urandom_range(0, i-1)];
        send_item(node_write(t, s, split_code(), c0, c1, rand_value()));
      end
    end
  endtask

  // straight chain of splits around the depth limit, root at slot 0
  task automatic build_chain(input int t);
    int depth;
    int base;
    int i;
    depth = $urandom_range(DEPTH_LIMIT-1, DEPTH_LIMIT+2);
    base = $urandom_range(1, NODES-2-depth);
    send_item(node_write(t, base+depth, leaf_code(), $urandom_range(0, NODES-1),
                         $urandom_range(0, NODES-1), rand_prob()));
    for (i = depth-1; i >= 0; i--)
      send_item(node_write(t, (i == 0) ? 0 : base+i, split_code(), base+i+1, base+i+1,
                           rand_value()));
  endtask

  task automatic run_features();
    int n;
    int i;
    n = $urandom_range(1, 5);
    for (i = 0; i < n; i++) send_item(feat_load(rand_feat_index(), rand_value(), i == n-1));
  endtask

  task automatic run_random_phase(input logic [TREE_COUNT_W-1:0] tc,
                                  input logic [PROB_W-1:0] thr, input int n_items);
    int target;
    int pick;
    bit chain_done;
    write_config(tc, thr);
    target = items_sent + n_items;
    chain_done = 1'b0;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (!chain_done && pick < 3) begin
        build_chain(pick_tree());
        chain_done = 1'b1;
      end else if (pick < 48) begin
        build_subtree(pick_tree());
      end else if (pick < 88) begin
        run_features();
      end else if (pick < 94) begin
        send_item(feat_load(rand_feat_index(), rand_value(), 1'b0));
      end else begin
        send_item(node_write(pick_tree(), $urandom_range(0, NODES-1), leaf_code(),
                             $urandom_range(0, NODES-1), $urandom_range(0, NODES-1),
                             rand_prob()));
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // every root a leaf and every feature loaded before the first walk
  task automatic load_base_forest();
    int i;
    for (i = 0; i < MAX_TREES; i++)
      send_item(node_write(i, 0, leaf_code(), $urandom_range(0, NODES-1),
                           $urandom_range(0, NODES-1), rand_prob()));
    for (i = 0; i < NUM_FEAT; i++) send_item(feat_load(i, rand_value(), 1'b0));
  endtask

  task automatic test_leaf_saturation();
    write_config(6'd2, 16'h1234);
    send_item(node_write(0, 0, 7'h40, 0, 0, 32'hFFFF_FFFB));
    send_item(node_write(1, 0, 7'h7F, NODES-1, NODES-1, 32'h7FFF_FFFF));
    send_item(feat_load(0, 32'h0, 1'b1));
  endtask

  task automatic test_split_direction();
    send_item(node_write(0, 1, 7'h7F, 0, 0, 32'h0000_2468));
    send_item(node_write(0, 2, 7'h7F, 0, 0, 32'h0001_0000));
    send_item(node_write(0, 0, 7'd3, 1, 2, 32'h0));
    send_item(feat_load(3, 32'h8000_0000, 1'b1));
    send_item(feat_load(3, 32'h0, 1'b1));
    send_item(feat_load(3, 32'h7FFF_FFFF, 1'b1));
    // split on a feature past the buffer compares zero
    send_item(node_write(0, 0, 7'd63, 1, 2, 32'h1));
    // load past the buffer stores nothing but still classifies
    send_item(feat_load(63, rand_value(), 1'b1));
  endtask

  task automatic test_walk_fault();
    send_item(node_write(1, 0, 7'd0, 0, 0, rand_value()));
    send_item(feat_load(0, rand_value(), 1'b1));
    send_item(node_write(1, 0, leaf_code(), 0, 0, rand_prob()));
  endtask

  task automatic test_decide_edge();
    write_config(6'd1, 16'h2468);
    send_item(feat_load(5, rand_value(), 1'b1));
    write_config(6'd1, 16'h2469);
    send_item(feat_load(5, rand_value(), 1'b1));
  endtask

  // result side held off for a long stretch while classifications queue up
  task automatic test_output_backpressure();
    int i;
    write_config(6'd12, 16'd32768);
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    for (i = 0; i < 4; i++) run_features();
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    run_random_phase(6'd12, 16'd32768, PHASE_ITEMS);
    run_random_phase(6'd0, 16'd0, PHASE_ITEMS);
    run_random_phase(6'd63, 16'hFFFF, PHASE_ITEMS);
    run_random_phase(6'd32, PROB_W'($urandom_range(0, 65535)), PHASE_ITEMS);
    run_random_phase(6'd1, PROB_W'($urandom_range(0, 65535)), PHASE_ITEMS);
    gaps_on = 1'b0;
    run_random_phase(TREE_COUNT_W'($urandom_range(2, 31)), PROB_W'($urandom_range(0, 65535)),
                     PHASE_ITEMS);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_TREE_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = REQ_NODE;
    tree_index = '0;
    node_index = '0;
    node_feature = '0;
    node_left = '0;
    node_right = '0;
    node_value = '0;
    feature_index = '0;
    feature_value = '0;
    last_feature = 1'b0;
    out_stall = 1'b0;
    tree_count_copy = TREE_COUNT_RESET;
    threshold_copy = THRESHOLD_RESET;
    fail_count = 0;
    items_sent = 0;
    verdicts_checked = 0;
    faults_seen = 0;
    cycle_count = 0;
    gaps_on = 1'b1;
    hold_request = 1'b0;
    hold_count = 0;
    burst_left = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_base_forest();
    test_leaf_saturation();
    test_split_direction();
    test_walk_fault();
    test_decide_edge();
    test_output_backpressure();
    test_random_traffic();

    wait_for_drain();
    repeat (50) @(negedge clk);
    $display("covered %0d input transfers and %0d classifications, %0d of them with a walk fault,",
             items_sent, verdicts_checked, faults_seen);
    $display("tree counts 0 through 63 and decide thresholds 0 through 65535");
    if (fail_count == 0) begin
      $display("random_forest_inference: match");
    end else begin
      $display("random_forest_inference: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rfi_pkg.sv
hw/rtl/rfi_div.sv
hw/rtl/rfi_ctrl.sv
hw/rtl/rfi_datapath.sv
hw/rtl/random_forest_inference.sv
verif/tb_random_forest_inference.sv
